### rtl/rrfr_pkg.sv
package rrfr_pkg;

  // Frame constants
  localparam logic [7:0]  HDR_FIRST   = 8'hAA;
  localparam logic [7:0]  HDR_SECOND  = 8'hBB;
  localparam logic [15:0] QUIRK_LEN   = 16'h000A;
  localparam logic [15:0] QUIRK_CMD   = 16'h0212;
  localparam logic [15:0] QUIRK_FIX   = 16'h000D;
  localparam logic [15:0] HDR_TAIL    = 16'd6;     // reserved, command, status and checksum bytes
  localparam logic [15:0] MAX_DATA    = 16'd255;   // payload byte limit

  // Register map
  localparam int unsigned CFG_AW          = 3;
  localparam logic        REG_EXP_CMD     = 1'b0;
  localparam logic        REG_TIMEOUT     = 1'b1;
  localparam logic [23:0] TIMEOUT_RST     = 24'd3000;

  // Result codes
  localparam logic [2:0] RC_OK       = 3'd0;
  localparam logic [2:0] RC_CSUM     = 3'd1;
  localparam logic [2:0] RC_STATUS   = 3'd2;
  localparam logic [2:0] RC_TIMEOUT  = 3'd3;
  localparam logic [2:0] RC_BAD_LEN  = 3'd4;

  typedef struct packed {
    logic [15:0] expected_command;
    logic [23:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] device_status;
    logic [2:0] result_code;
    logic [7:0] data_count;
    logic       last;
  } res_t;

endpackage

### rtl/rrfr_cfg.sv
module rrfr_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [rrfr_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready,
  output rrfr_pkg::cfg_t                cfg
);

  logic        wr_en;
  logic        reg_sel;
  logic [15:0] exp_cmd_r;
  logic [23:0] timeout_r;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign reg_sel    = cfg_paddr[2];

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_cmd_r <= '0;
      timeout_r <= rrfr_pkg::TIMEOUT_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        rrfr_pkg::REG_EXP_CMD: exp_cmd_r <= cfg_pwdata[15:0];
        rrfr_pkg::REG_TIMEOUT: timeout_r <= cfg_pwdata[23:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_sel)
      rrfr_pkg::REG_EXP_CMD: cfg_prdata = {16'd0, exp_cmd_r};
      rrfr_pkg::REG_TIMEOUT: cfg_prdata = {8'd0, timeout_r};
      default:               cfg_prdata = '0;
    endcase
  end

  assign cfg.expected_command = exp_cmd_r;
  assign cfg.timeout_ticks    = timeout_r;

endmodule

### rtl/rrfr_parser.sv
module rrfr_parser #(
  parameter logic [15:0] MAX_DATA = rrfr_pkg::MAX_DATA
) (
  input  logic            clk,
  input  logic            rst_n,
  input  rrfr_pkg::cfg_t  cfg,
  input  logic            acc,
  input  logic            is_tick,
  input  logic [7:0]      rx_byte,
  output logic            res_valid,
  output rrfr_pkg::res_t  res
);

  typedef enum logic [3:0] {
    PH_HUNT, PH_LEN_LO, PH_LEN_HI, PH_RES0, PH_RES1,
    PH_CMD_LO, PH_CMD_HI, PH_STATUS, PH_DATA, PH_CSUM
  } phase_t;

  phase_t      phase_r,    phase_nxt;
  logic        armed_r,    armed_nxt;
  logic [7:0]  len_lo_r,   len_lo_nxt;
  logic [7:0]  data_len_r, data_len_nxt;
  logic [7:0]  cmd_lo_r,   cmd_lo_nxt;
  logic [7:0]  xor_r,      xor_nxt;
  logic [7:0]  status_r,   status_nxt;
  logic [7:0]  left_r,     left_nxt;
  logic [23:0] idle_r,     idle_nxt;

  logic [24:0] tick_sum;
  logic [15:0] len_raw;
  logic [15:0] len_eff;
  logic [15:0] len_pay;
  logic        len_bad;
  logic [15:0] cmd_full;

  assign tick_sum = {1'b0, idle_r} + 25'd1;
  assign len_raw  = {rx_byte, len_lo_r};
  assign len_eff  = (len_raw == rrfr_pkg::QUIRK_LEN &&
                     cfg.expected_command == rrfr_pkg::QUIRK_CMD) ?
                    rrfr_pkg::QUIRK_FIX : len_raw;
  assign len_pay  = len_eff - rrfr_pkg::HDR_TAIL;
  assign len_bad  = (len_eff < rrfr_pkg::HDR_TAIL) || (len_pay > MAX_DATA);
  assign cmd_full = {rx_byte, cmd_lo_r};

  // Per-item state update
  always_comb begin
    phase_nxt    = phase_r;
    armed_nxt    = armed_r;
    len_lo_nxt   = len_lo_r;
    data_len_nxt = data_len_r;
    cmd_lo_nxt   = cmd_lo_r;
    xor_nxt      = xor_r;
    status_nxt   = status_r;
    left_nxt     = left_r;
    idle_nxt     = idle_r;
    res_valid    = 1'b0;
    res          = '0;
    if (acc) begin
      if (is_tick) begin
        if (tick_sum >= {1'b0, cfg.timeout_ticks}) begin
          idle_nxt        = '0;
          phase_nxt       = PH_HUNT;
          armed_nxt       = 1'b0;
          res_valid       = 1'b1;
          res.result_code = rrfr_pkg::RC_TIMEOUT;
          res.last        = 1'b1;
        end else begin
          idle_nxt = tick_sum[23:0];
        end
      end else begin
        idle_nxt = '0;
        unique case (phase_r)
          PH_HUNT: begin
            if (armed_r && rx_byte == rrfr_pkg::HDR_SECOND) begin
              armed_nxt = 1'b0;
              phase_nxt = PH_LEN_LO;
            end else begin
              armed_nxt = (rx_byte == rrfr_pkg::HDR_FIRST);
            end
          end
          PH_LEN_LO: begin
            len_lo_nxt = rx_byte;
            phase_nxt  = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            if (len_bad) begin
              phase_nxt       = PH_HUNT;
              armed_nxt       = 1'b0;
              res_valid       = 1'b1;
              res.result_code = rrfr_pkg::RC_BAD_LEN;
              res.last        = 1'b1;
            end else begin
              data_len_nxt = len_pay[7:0];
              xor_nxt      = '0;
              phase_nxt    = PH_RES0;
            end
          end
          PH_RES0: begin
            xor_nxt   = xor_r ^ rx_byte;
            phase_nxt = PH_RES1;
          end
          PH_RES1: begin
            xor_nxt   = xor_r ^ rx_byte;
            phase_nxt = PH_CMD_LO;
          end
          PH_CMD_LO: begin
            cmd_lo_nxt = rx_byte;
            phase_nxt  = PH_CMD_HI;
          end
          PH_CMD_HI: begin
            if (cmd_full != cfg.expected_command) begin
              // wrong command: drop silently
              phase_nxt = PH_HUNT;
              armed_nxt = 1'b0;
            end else begin
              xor_nxt   = xor_r ^ cmd_lo_r ^ rx_byte;
              phase_nxt = PH_STATUS;
            end
          end
          PH_STATUS: begin
            status_nxt = rx_byte;
            xor_nxt    = xor_r ^ rx_byte;
            left_nxt   = data_len_r;
            phase_nxt  = (data_len_r == 8'd0) ? PH_CSUM : PH_DATA;
          end
          PH_DATA: begin
            xor_nxt           = xor_r ^ rx_byte;
            left_nxt          = left_r - 8'd1;
            if (left_r == 8'd1) begin
              phase_nxt = PH_CSUM;
            end
            res_valid         = 1'b1;
            res.data_byte     = rx_byte;
            res.device_status = status_r;
          end
          PH_CSUM: begin
            phase_nxt         = PH_HUNT;
            armed_nxt         = 1'b0;
            res_valid         = 1'b1;
            res.device_status = status_r;
            res.data_count    = data_len_r;
            res.last          = 1'b1;
            if (rx_byte != xor_r) begin
              res.result_code = rrfr_pkg::RC_CSUM;
            end else if (status_r != 8'd0) begin
              res.result_code = rrfr_pkg::RC_STATUS;
            end else begin
              res.result_code = rrfr_pkg::RC_OK;
            end
          end
          default: begin
            phase_nxt = PH_HUNT;
            armed_nxt = 1'b0;
          end
        endcase
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT;
      armed_r    <= 1'b0;
      len_lo_r   <= '0;
      data_len_r <= '0;
      cmd_lo_r   <= '0;
      xor_r      <= '0;
      status_r   <= '0;
      left_r     <= '0;
      idle_r     <= '0;
    end else begin
      phase_r    <= phase_nxt;
      armed_r    <= armed_nxt;
      len_lo_r   <= len_lo_nxt;
      data_len_r <= data_len_nxt;
      cmd_lo_r   <= cmd_lo_nxt;
      xor_r      <= xor_nxt;
      status_r   <= status_nxt;
      left_r     <= left_nxt;
      idle_r     <= idle_nxt;
    end
  end

endmodule

### rtl/rrfr_out_buf.sv
module rrfr_out_buf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rrfr_pkg::res_t  push_data,
  output logic            space,
  output logic            out_valid,
  input  logic            out_ready,
  output rrfr_pkg::res_t  out_data
);

  logic           out_valid_r;
  logic           skid_valid_r;
  rrfr_pkg::res_t out_r;
  rrfr_pkg::res_t skid_r;
  logic           slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign space     = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Control: output slot refills from skid first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (slot_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (slot_free) begin
      out_r <= skid_valid_r ? skid_r : push_data;
    end else if (push) begin
      skid_r <= push_data;
    end
  end

endmodule

### rtl/reader_response_frame_receiver.sv
// Reader response frame receiver. Each input transfer carries one received
// byte (in_tuser = 0) or one time tick (in_tuser = 1). The block hunts for the
// AA BB header, parses length, reserved, command and status fields, streams
// the payload bytes out as they arrive (tlast = 0), and closes each frame,
// timeout or bad length with one tlast = 1 transfer carrying the result code.
// Frames whose command differs from expected_command are dropped silently.
// MAX_DATA sets the largest payload length accepted.
// Throughput is one input transfer per clock: the parser computes its next
// state and result combinationally, and results land in a two-entry output
// register with skid stage, so in_tready drops only when both entries hold
// untaken results. Results pass through the skid stage only when stalled.
module reader_response_frame_receiver #(
  parameter logic [15:0] MAX_DATA = rrfr_pkg::MAX_DATA
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input stream
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // [7:0] rx_byte
  input  logic                         in_tuser,   // [0] is_tick
  // result stream
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [31:0]                  out_tdata,  // [7:0] data_byte, [15:8] device_status,
                                                   // [18:16] result_code, [26:19] data_count
  output logic                         out_tlast,
  // configuration
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [rrfr_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [31:0]                  cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready
);

  rrfr_pkg::cfg_t cfg;
  rrfr_pkg::res_t res;
  rrfr_pkg::res_t out_res;
  logic           res_valid;
  logic           in_acc;
  logic           space;

  assign in_tready = space;
  assign in_acc    = in_tvalid & in_tready;

  rrfr_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  rrfr_parser #(
    .MAX_DATA (MAX_DATA)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .acc       (in_acc),
    .is_tick   (in_tuser),
    .rx_byte   (in_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  rrfr_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .space     (space),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  // Pack result fields, data_byte in the lowest bits
  assign out_tdata = {5'd0, out_res.data_count, out_res.result_code,
                      out_res.device_status, out_res.data_byte};
  assign out_tlast = out_res.last;

endmodule
